### rtl/snl_pkg.sv
// Package for the Sobel / non-maximum suppression / double threshold block.
// Holds the shared widths, register indexes, direction codes and border type.
// No dependencies.
package snl_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int THR_W     = 11;
  localparam int THR_SQ_W  = 2 * THR_W;
  localparam int ABS_W     = 10;
  localparam int SQ_W      = 2 * ABS_W;
  localparam int MAG_W     = SQ_W + 1;
  localparam int DIR_W     = 2;
  localparam int CLS_W     = 2;
  localparam int PROD_W    = 20;
  localparam int POS_W     = 23;
  localparam int ROW_W     = FH_W;
  localparam int GROW_W    = FH_W + 1;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Tangent bounds of 22.5 and 67.5 degrees in 8-bit fraction fixed point.
  localparam int TAN_LO    = 106;
  localparam int TAN_HI    = 618;

  localparam logic [FW_W-1:0]  FW_RESET  = 11'd1024;
  localparam logic [FH_W-1:0]  FH_RESET  = 12'd768;
  localparam logic [THR_W-1:0] THR_RESET = 11'd20;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LOW    = 2'd2,
    REG_HIGH   = 2'd3
  } reg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORZ = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_VERT = 2'd2,
    DIR_ANTI = 2'd3
  } dir_t;

  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WEAK   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_STRONG = 2'd2;
  localparam logic [CLS_W-1:0] CLS_UNUSED = 2'd3;

  // Which sides of a 3x3 neighborhood fall outside the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

endpackage

### rtl/snl_ram.sv
// Simple dual-port RAM with a registered read port, used for the line stores.
// Depends on nothing.
module snl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/snl_sobel.sv
// Sobel gradient of a 3x3 window with zero outside the frame, and direction sector.
// Depends on snl_pkg.
module snl_sobel import snl_pkg::*; (
  input  logic [2:0][2:0][PIX_W-1:0] win,
  input  border_t                    border,
  output logic [ABS_W-1:0]           abs_x,
  output logic [ABS_W-1:0]           abs_y,
  output logic [DIR_W-1:0]           dir
);

  logic [2:0][2:0][PIX_W-1:0] v;
  logic [ABS_W-1:0]           pos_x, neg_x, pos_y, neg_y;
  logic [PROD_W-1:0]          ay_scaled, lo_prod, hi_prod;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && border.top) || (r == 2 && border.bottom) ||
            (c == 0 && border.left) || (c == 2 && border.right)) begin
          v[r][c] = '0;
        end else begin
          v[r][c] = win[r][c];
        end
      end
    end
  end

  assign pos_x = ABS_W'(v[0][2]) + ABS_W'({v[1][2], 1'b0}) + ABS_W'(v[2][2]);
  assign neg_x = ABS_W'(v[0][0]) + ABS_W'({v[1][0], 1'b0}) + ABS_W'(v[2][0]);
  assign pos_y = ABS_W'(v[2][0]) + ABS_W'({v[2][1], 1'b0}) + ABS_W'(v[2][2]);
  assign neg_y = ABS_W'(v[0][0]) + ABS_W'({v[0][1], 1'b0}) + ABS_W'(v[0][2]);

  assign abs_x = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
  assign abs_y = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;

  assign ay_scaled = PROD_W'(abs_y) << 8;
  assign lo_prod   = PROD_W'(abs_x) * PROD_W'(TAN_LO);
  assign hi_prod   = PROD_W'(abs_x) * PROD_W'(TAN_HI);

  always_comb begin
    priority if (ay_scaled <= lo_prod) begin
      dir = DIR_HORZ;
    end else if (ay_scaled > hi_prod) begin
      dir = DIR_VERT;
    end else if ((pos_x > neg_x) == (pos_y > neg_y)) begin
      dir = DIR_DIAG;
    end else begin
      dir = DIR_ANTI;
    end
  end

endmodule

### rtl/sobel_nms_double_threshold.sv
// Top level: streaming Sobel gradient, non-maximum suppression and double threshold.
// Depends on snl_pkg, snl_ram and snl_sobel.
//
//   channel   signals                                        direction
//   input     in_valid, in_stall, mode, pixel                into block
//   output    out_valid, out_stall, edge_class,
//             magnitude_sq, direction, end_of_frame          out of block
//   config    psel, penable, pwrite, paddr, pwdata,
//             prdata, pready                                 APB-style slave
//
// One transaction is taken every clock while in_stall is low. A result passes
// from the input register through the gray window, the squared components and
// the magnitude window to the output register. The result for frame position q is
// released by the transaction at stream position q + 2*W + 2 (W = row width in use).
// Reset is synchronous and clears control state only; line stores need no clearing.
// in_stall rises only when the output register and its skid register both hold a
// result, so the input side sees the output stall through the registered skid flag.
module sobel_nms_double_threshold import snl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CLS_W-1:0]  edge_class,
  output logic [MAG_W-1:0]  magnitude_sq,
  output logic [DIR_W-1:0]  direction,
  output logic              end_of_frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int GW_W = 2 * MAG_W + DIR_W;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [MAG_W-1:0] mag;
    logic [DIR_W-1:0] dir;
    logic             last;
  } result_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Geometry writes restart the frame counters.
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0]     frame_width;
  logic [FH_W-1:0]     frame_height;
  logic [THR_W-1:0]    low_threshold;
  logic [THR_W-1:0]    high_threshold;
  logic                cfg_wr, geom_wr;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign geom_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FW_RESET;
      frame_height   <= FH_RESET;
      low_threshold  <= THR_RESET;
      high_threshold <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  frame_width    <= pwdata[FW_W-1:0];
        REG_HEIGHT: frame_height   <= pwdata[FH_W-1:0];
        REG_LOW:    low_threshold  <= pwdata[THR_W-1:0];
        REG_HIGH:   high_threshold <= pwdata[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = DATA_W'(frame_width);
      REG_HEIGHT: prdata = DATA_W'(frame_height);
      REG_LOW:    prdata = DATA_W'(low_threshold);
      REG_HIGH:   prdata = DATA_W'(high_threshold);
    endcase
  end

  // Geometry in use: width at least one and clamped to the line store size, height at least one.
  logic [FW_W-1:0]     w_eff, w_m1;
  logic [FH_W-1:0]     h_eff, h_m1;
  logic [POS_W-1:0]    total, w_plus1, w2_plus2;
  logic [THR_SQ_W-1:0] lo_sq, hi_sq;

  always_comb begin
    priority if (frame_width == '0) begin
      w_eff = FW_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
  end

  assign h_eff    = (frame_height == '0) ? FH_W'(1) : frame_height;
  assign w_m1     = w_eff - FW_W'(1);
  assign h_m1     = h_eff - FH_W'(1);
  assign w_plus1  = POS_W'(w_eff) + POS_W'(1);
  assign w2_plus2 = (POS_W'(w_eff) << 1) + POS_W'(2);

  // The products follow the registers directly, so a write is seen by the very
  // next transaction.
  assign total = POS_W'(w_eff) * POS_W'(h_eff);
  assign lo_sq = THR_SQ_W'(low_threshold) * THR_SQ_W'(low_threshold);
  assign hi_sq = THR_SQ_W'(high_threshold) * THR_SQ_W'(high_threshold);

  // ---------------------------------------------------------------------------
  // Stream position counters. p_pos is the next stream position, (g_row, g_col)
  // the next gradient position (p - W - 1) and (q_row, q_col) the next result.
  // ---------------------------------------------------------------------------
  logic               en, accept, in_frame, active, gstep, emit, last;
  logic               skid_v, out_v;
  logic [POS_W-1:0]   p_pos;
  logic [COL_W-1:0]   in_col, g_col, q_col;
  logic [GROW_W-1:0]  g_row;
  logic [ROW_W-1:0]   q_row;
  border_t            g_border, q_border;

  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign accept   = in_valid && en;
  assign in_frame = p_pos < total;
  // A drain transaction before the frame is complete is taken but has no effect.
  assign active   = accept && !(in_frame && mode);
  assign gstep    = p_pos >= w_plus1;
  assign emit     = p_pos >= w2_plus2;
  assign last     = emit && (q_row == h_m1) && (FW_W'(q_col) == w_m1);

  assign g_border.top    = (g_row == '0);
  assign g_border.bottom = (g_row >= GROW_W'(h_m1));
  assign g_border.left   = (g_col == '0);
  assign g_border.right  = (FW_W'(g_col) == w_m1);
  assign q_border.top    = (q_row == '0);
  assign q_border.bottom = (q_row >= h_m1);
  assign q_border.left   = (q_col == '0);
  assign q_border.right  = (FW_W'(q_col) == w_m1);

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      p_pos  <= '0;
      in_col <= '0;
      g_col  <= '0;
      g_row  <= '0;
      q_col  <= '0;
      q_row  <= '0;
    end else if (active) begin
      if (last) begin
        // The frame's final result restarts every counter.
        p_pos  <= '0;
        in_col <= '0;
        g_col  <= '0;
        g_row  <= '0;
        q_col  <= '0;
        q_row  <= '0;
      end else begin
        p_pos  <= p_pos + POS_W'(1);
        in_col <= (FW_W'(in_col) == w_m1) ? '0 : in_col + COL_W'(1);
        if (gstep) begin
          if (FW_W'(g_col) == w_m1) begin
            g_col <= '0;
            g_row <= g_row + GROW_W'(1);
          end else begin
            g_col <= g_col + COL_W'(1);
          end
        end
        if (emit) begin
          if (FW_W'(q_col) == w_m1) begin
            q_col <= '0;
            q_row <= q_row + ROW_W'(1);
          end else begin
            q_col <= q_col + COL_W'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register and gray line store read (rows p-W and p-2W).
  // All stages advance together under en.
  // ---------------------------------------------------------------------------
  logic                 v1, gstep1, emit1, last1, s1_fire;
  logic [PIX_W-1:0]     pix1;
  logic [COL_W-1:0]     col1, gcol1;
  border_t              gb1, qb1;
  logic [2*PIX_W-1:0]   gray_rd, gray_word1, gray_wr, gfwd_data;
  logic                 gfwd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix1   <= in_frame ? pixel : '0;
      col1   <= in_col;
      gstep1 <= gstep;
      gb1    <= g_border;
      gcol1  <= g_col;
      emit1  <= emit;
      qb1    <= q_border;
      last1  <= last;
    end
  end

  assign s1_fire = en && v1;

  // A store entry holds the pixels of rows p-W (upper half) and p-2W (lower half).
  assign gray_word1 = gfwd_hit ? gfwd_data : gray_rd;
  assign gray_wr    = {pix1, gray_word1[2*PIX_W-1:PIX_W]};

  snl_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * PIX_W)
  ) u_gray_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (col1),
    .wdata (gray_wr),
    .re    (en),
    .raddr (in_col),
    .rdata (gray_rd)
  );

  // Same-column write and read in one cycle (one-pixel rows) bypass the RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      gfwd_hit <= 1'b0;
    end else if (en) begin
      gfwd_hit <= s1_fire && (col1 == in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gfwd_data <= gray_wr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: 3x3 gray window, centered on gradient position g = p - W - 1.
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][PIX_W-1:0] gwin;
  logic                       v2, gstep2, emit2, last2, s2_fire;
  logic [COL_W-1:0]           gcol2;
  border_t                    gb2, qb2;
  logic [ABS_W-1:0]           abs_x, abs_y;
  logic [DIR_W-1:0]           dir2;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        gwin[r][0] <= gwin[r][1];
        gwin[r][1] <= gwin[r][2];
      end
      gwin[0][2] <= gray_word1[PIX_W-1:0];
      gwin[1][2] <= gray_word1[2*PIX_W-1:PIX_W];
      gwin[2][2] <= pix1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gstep2 <= gstep1;
      gb2    <= gb1;
      gcol2  <= gcol1;
      emit2  <= emit1;
      qb2    <= qb1;
      last2  <= last1;
    end
  end

  assign s2_fire = en && v2;

  snl_sobel u_sobel (
    .win    (gwin),
    .border (gb2),
    .abs_x  (abs_x),
    .abs_y  (abs_y),
    .dir    (dir2)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: squared components, gradient line store read (rows g-W, g-2W).
  // ---------------------------------------------------------------------------
  logic               v3, gstep3, emit3, last3, s3_gwrite;
  logic [SQ_W-1:0]    sqx, sqy;
  logic [DIR_W-1:0]   dir3;
  logic [COL_W-1:0]   gcol3;
  border_t            qb3;
  logic [MAG_W-1:0]   mag3;
  logic [GW_W-1:0]    grad_rd, grad_word3, grad_wr, mfwd_data;
  logic               mfwd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx    <= SQ_W'(abs_x) * SQ_W'(abs_x);
      sqy    <= SQ_W'(abs_y) * SQ_W'(abs_y);
      dir3   <= dir2;
      gstep3 <= gstep2;
      gcol3  <= gcol2;
      emit3  <= emit2;
      qb3    <= qb2;
      last3  <= last2;
    end
  end

  assign mag3      = MAG_W'(sqx) + MAG_W'(sqy);
  assign s3_gwrite = en && v3 && gstep3;

  // Entry layout: magnitude and direction of row g-W, then magnitude of row g-2W.
  assign grad_word3 = mfwd_hit ? mfwd_data : grad_rd;
  assign grad_wr    = {mag3, dir3, grad_word3[GW_W-1:MAG_W+DIR_W]};

  snl_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (GW_W)
  ) u_grad_ram (
    .clk   (clk),
    .we    (s3_gwrite),
    .waddr (gcol3),
    .wdata (grad_wr),
    .re    (en),
    .raddr (gcol2),
    .rdata (grad_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mfwd_hit <= 1'b0;
    end else if (en) begin
      mfwd_hit <= s3_gwrite && (gcol3 == gcol2) && s2_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mfwd_data <= grad_wr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: 3x3 magnitude window centered on result position q = g - W - 1,
  // suppression along the center direction and the double threshold.
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][MAG_W-1:0] mwin, mm;
  logic [DIR_W-1:0]           dir_r, dir_c;
  logic                       v4, last4, push, suppress;
  border_t                    qb4;
  logic [MAG_W-1:0]           mag_c, nb_a, nb_b;
  result_t                    res, out_d, skid_d;

  always_ff @(posedge clk) begin
    if (s3_gwrite) begin
      for (int r = 0; r < 3; r++) begin
        mwin[r][0] <= mwin[r][1];
        mwin[r][1] <= mwin[r][2];
      end
      mwin[0][2] <= grad_word3[MAG_W-1:0];
      mwin[1][2] <= grad_word3[GW_W-1:MAG_W+DIR_W];
      mwin[2][2] <= mag3;
      dir_r      <= grad_word3[MAG_W+DIR_W-1:MAG_W];
      dir_c      <= dir_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3 && emit3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qb4   <= qb3;
      last4 <= last3;
    end
  end

  // Neighbor magnitudes outside the frame count as zero.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && qb4.top) || (r == 2 && qb4.bottom) ||
            (c == 0 && qb4.left) || (c == 2 && qb4.right)) begin
          mm[r][c] = '0;
        end else begin
          mm[r][c] = mwin[r][c];
        end
      end
    end
  end

  assign mag_c = mwin[1][1];

  always_comb begin
    unique case (dir_t'(dir_c))
      DIR_HORZ: begin
        nb_a = mm[1][0];
        nb_b = mm[1][2];
      end
      DIR_DIAG: begin
        nb_a = mm[0][0];
        nb_b = mm[2][2];
      end
      DIR_VERT: begin
        nb_a = mm[0][1];
        nb_b = mm[2][1];
      end
      DIR_ANTI: begin
        nb_a = mm[0][2];
        nb_b = mm[2][0];
      end
    endcase
  end

  assign suppress = (mag_c < nb_a) || (mag_c < nb_b);

  // The strong test goes first, so a high threshold below the low one still wins.
  always_comb begin
    res.dir  = dir_c;
    res.last = last4;
    res.mag  = suppress ? '0 : mag_c;
    priority if (suppress) begin
      res.cls = CLS_NONE;
    end else if (THR_SQ_W'(mag_c) >= hi_sq) begin
      res.cls = CLS_STRONG;
    end else if (THR_SQ_W'(mag_c) >= lo_sq) begin
      res.cls = CLS_WEAK;
    end else begin
      res.cls = CLS_NONE;
    end
  end

  assign push = en && v4;

  // ---------------------------------------------------------------------------
  // Output register with a one-entry skid register behind it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || !out_stall) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v  <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || !out_stall) begin
      if (skid_v) begin
        out_d <= skid_d;
      end else if (push) begin
        out_d <= res;
      end
    end
    if (push && out_v && out_stall) begin
      skid_d <= res;
    end
  end

  assign out_valid    = out_v;
  assign edge_class   = out_d.cls;
  assign magnitude_sq = out_d.mag;
  assign direction    = out_d.dir;
  assign end_of_frame = out_d.last;

endmodule

### rtl/snl_checker.sv
// Port-level checks for the Sobel / suppression / threshold block, and their binding.
// Depends on snl_pkg and the top level sobel_nms_double_threshold.
module snl_checker import snl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CLS_W-1:0]  edge_class,
  input logic [MAG_W-1:0]  magnitude_sq,
  input logic [DIR_W-1:0]  direction,
  input logic              end_of_frame
);

  // Nothing is offered and nothing is held back right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // The input side is held back only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // An offered result never carries the unused class code.
  a_class_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> edge_class != CLS_UNUSED)
    else $error("unused edge class code");

  // A stalled transaction keeps its result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude_sq) &&
    $stable(edge_class) && $stable(direction) && $stable(end_of_frame))
    else $error("stalled result changed");

endmodule

bind sobel_nms_double_threshold snl_checker u_snl_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for sobel_nms_double_threshold: streams gray frames, predicts each edge
// result in a behavioral model of its own and checks every output transaction.
// Depends on snl_pkg and the block's RTL.
module tb;
  import snl_pkg::*;

  // Gradient and gray histories are indexed by stream position modulo this depth.
  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 4;
  localparam int IDLE_WAIT  = 12;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [CLS_W-1:0] cls;
    logic [MAG_W-1:0] mag;
    dir_t             dir;
    logic             eof;
  } edge_result_t;

  typedef enum int {
    PAT_RANDOM, PAT_BRIGHT, PAT_DARK, PAT_VSTEP, PAT_HSTEP, PAT_DIAG, PAT_ANTI
  } pattern_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = 1'b0;
  logic [PIX_W-1:0]  pixel = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CLS_W-1:0]  edge_class;
  logic [MAG_W-1:0]  magnitude_sq;
  logic [DIR_W-1:0]  direction;
  logic              end_of_frame;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sobel_nms_double_threshold dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall), .edge_class(edge_class),
    .magnitude_sq(magnitude_sq), .direction(direction), .end_of_frame(end_of_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: register copies, the two histories and the four counters.
  int unsigned  width_reg = FW_RESET;
  int unsigned  height_reg = FH_RESET;
  int unsigned  low_thr = THR_RESET;
  int unsigned  high_thr = THR_RESET;
  int unsigned  gray_hist [HIST_DEPTH];
  int unsigned  grad_hist [HIST_DEPTH];
  int unsigned  in_col, in_row, out_col, out_row;

  edge_result_t edge_results_q[$];
  int           mismatches = 0;
  int           pixels_sent = 0;
  bit           quiet = 0;
  int           hold_tag = 0;

  function automatic int unsigned frame_w();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg < 1) ? 1 : height_reg;
  endfunction

  function automatic int gray_px(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 0;
    return gray_hist[(r * w + c) % HIST_DEPTH];
  endfunction

  function automatic int unsigned mag_px(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 0;
    return grad_hist[(r * w + c) % HIST_DEPTH] & 32'h1F_FFFF;
  endfunction

  // Sobel gradient at (r, c): magnitude squared in bits 20:0, sector in 22:21.
  function automatic int unsigned sobel_at(int r, int c, int w, int h);
    int gx, gy, ax, ay;
    int unsigned mag, sector;
    gx = gray_px(r-1, c+1, w, h) + 2*gray_px(r, c+1, w, h) + gray_px(r+1, c+1, w, h)
       - gray_px(r-1, c-1, w, h) - 2*gray_px(r, c-1, w, h) - gray_px(r+1, c-1, w, h);
    gy = gray_px(r+1, c-1, w, h) + 2*gray_px(r+1, c, w, h) + gray_px(r+1, c+1, w, h)
       - gray_px(r-1, c-1, w, h) - 2*gray_px(r-1, c, w, h) - gray_px(r-1, c+1, w, h);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    mag = ax * ax + ay * ay;
    if (256 * ay <= TAN_LO * ax) sector = DIR_HORZ;
    else if (256 * ay > TAN_HI * ax) sector = DIR_VERT;
    else if ((gx > 0) == (gy > 0)) sector = DIR_DIAG;
    else sector = DIR_ANTI;
    return (mag & 32'h1F_FFFF) | (sector << 21);
  endfunction

  // Advances the model by one accepted input transaction and queues any result.
  task automatic predict_transaction(input logic m, input logic [PIX_W-1:0] px);
    int w, h, total, p, g, q, r, c;
    int unsigned grad_word, mag, a, b;
    edge_result_t res;
    w = frame_w();
    h = frame_h();
    total = w * h;
    p = in_row * w + in_col;
    if (p < total) begin
      // A drain before the frame is complete is simply dropped.
      if (m) return;
      gray_hist[p % HIST_DEPTH] = px;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (p >= w + 1) begin
      g = p - w - 1;
      if (g < total) grad_hist[g % HIST_DEPTH] = sobel_at(g / w, g % w, w, h);
    end
    if (p < 2 * w + 2) return;
    q = out_row * w + out_col;
    r = out_row;
    c = out_col;
    grad_word = grad_hist[q % HIST_DEPTH];
    mag = grad_word & 32'h1F_FFFF;
    res.dir = dir_t'(grad_word[22:21]);
    case (res.dir)
      DIR_HORZ: begin a = mag_px(r, c-1, w, h);   b = mag_px(r, c+1, w, h);   end
      DIR_DIAG: begin a = mag_px(r-1, c-1, w, h); b = mag_px(r+1, c+1, w, h); end
      DIR_VERT: begin a = mag_px(r-1, c, w, h);   b = mag_px(r+1, c, w, h);   end
      default:  begin a = mag_px(r-1, c+1, w, h); b = mag_px(r+1, c-1, w, h); end
    endcase
    if (mag < a || mag < b) begin
      mag = 0;
      res.cls = CLS_NONE;
    end else if (mag >= high_thr * high_thr) res.cls = CLS_STRONG;
    else if (mag >= low_thr * low_thr) res.cls = CLS_WEAK;
    else res.cls = CLS_NONE;
    res.mag = MAG_W'(mag);
    res.eof = (q + 1 >= total);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (res.eof) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    edge_results_q = {edge_results_q, res};
  endtask

  // Mostly no gap at all, some short ones, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Sends one input transaction, holding it until the block accepts it.
  task automatic send_item(input logic m, input logic [PIX_W-1:0] px);
    int gap;
    in_valid <= 1'b1;
    mode <= m;
    pixel <= px;
    do @(posedge clk); while (in_stall);
    predict_transaction(m, px);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering input, waits until every expected result has come back, then
  // lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (edge_results_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle, which performs the write.
  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        width_reg = value & 32'h7FF;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      REG_HEIGHT: begin
        height_reg = value & 32'hFFF;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      REG_LOW:  low_thr = value & 32'h7FF;
      REG_HIGH: high_thr = value & 32'h7FF;
    endcase
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic set_thresholds(input int unsigned lo, input int unsigned hi);
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
  endtask

  function automatic logic [PIX_W-1:0] pattern_px(pattern_t pat, int r, int c, int w);
    case (pat)
      PAT_BRIGHT: return 8'hFF;
      PAT_DARK:   return 8'h00;
      PAT_VSTEP:  return (2 * c >= w) ? 8'hFF : 8'h00;
      PAT_HSTEP:  return (r >= 1) ? 8'hFF : 8'h00;
      PAT_DIAG:   return (r > c) ? 8'hFF : 8'h00;
      PAT_ANTI:   return (r + c >= w) ? 8'hC8 : 8'h10;
      default:    return PIX_W'($urandom);
    endcase
  endfunction

  // One whole frame and its flush. With noise set, stray drain transactions are
  // mixed in mid-frame, and the flush uses pixels as well as drain items.
  task automatic send_frame(input pattern_t pat, input bit noise);
    int w, h;
    w = frame_w();
    h = frame_h();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (noise && $urandom_range(19) == 0) send_item(1'b1, PIX_W'($urandom));
        send_item(1'b0, pattern_px(pat, r, c, w));
        pixels_sent++;
      end
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      if (noise) send_item(1'($urandom), PIX_W'($urandom));
      else send_item(1'b1, 8'h00);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off whenever hold_tag moves.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(7) == 0) begin
      stall_left <= pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every accepted output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (edge_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: class %0d mag %0d dir %0d eof %0d",
                   edge_class, magnitude_sq, direction, end_of_frame);
      end else begin
        want = edge_results_q.pop_front();
        if (edge_class !== want.cls || magnitude_sq !== want.mag ||
            direction !== want.dir || end_of_frame !== want.eof) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected class %0d mag %0d dir %0d eof %0d, got %0d %0d %0d %0d",
                     want.cls, want.mag, want.dir, want.eof,
                     edge_class, magnitude_sq, direction, end_of_frame);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction anywhere.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default thresholds straight out of reset on a small frame.
  task automatic test_reset_thresholds();
    set_geometry(5, 4);
    send_frame(PAT_RANDOM, 0);
    wait_idle();
  endtask

  // Small frames whose patterns drive each gradient sector and both borders.
  task automatic test_patterns();
    set_geometry(4, 3);
    set_thresholds(0, 0);
    send_frame(PAT_DARK, 0);
    send_frame(PAT_BRIGHT, 0);
    wait_idle();
    set_thresholds(200, 50);
    send_frame(PAT_VSTEP, 1);
    send_frame(PAT_HSTEP, 1);
    wait_idle();
    set_thresholds(2047, 1443);
    send_frame(PAT_DIAG, 0);
    send_frame(PAT_ANTI, 1);
    wait_idle();
  endtask

  // Register extremes: zero width and height act as one; a tall one-pixel column.
  task automatic test_geometry_extremes();
    set_thresholds(30, 90);
    set_geometry(0, 0);
    send_frame(PAT_RANDOM, 1);
    wait_idle();
    set_geometry(1, 200);
    send_frame(PAT_RANDOM, 0);
    wait_idle();
    set_geometry(3, 2);
    send_frame(PAT_RANDOM, 1);
    wait_idle();
  endtask

  // A geometry write in the middle of a frame throws the partial frame away.
  task automatic test_geometry_restart();
    set_geometry(6, 5);
    for (int i = 0; i < 13; i++) send_item(1'b0, PIX_W'($urandom));
    wait_idle();
    write_reg(REG_WIDTH, 5);
    send_frame(PAT_RANDOM, 0);
    wait_idle();
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    set_geometry(8, 6);
    quiet = 1;
    hold_tag++;
    send_frame(PAT_RANDOM, 0);
    quiet = 0;
    wait_idle();
  endtask

  // Random geometry and thresholds, mostly small frames with occasional wide ones.
  task automatic test_random_frames();
    int target;
    target = pixels_sent + 900;
    while (pixels_sent < target) begin
      if ($urandom_range(9) == 0) set_geometry($urandom_range(48, 13), $urandom_range(4, 1));
      else set_geometry($urandom_range(12, 1), $urandom_range(10, 1));
      if ($urandom_range(3) == 0)
        set_thresholds($urandom_range(2047), $urandom_range(2047));
      else
        set_thresholds($urandom_range(150), $urandom_range(400));
      quiet = ($urandom_range(4) == 0);
      repeat ($urandom_range(3, 1)) send_frame(PAT_RANDOM, $urandom_range(3) == 0);
      quiet = 0;
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_thresholds();
    test_patterns();
    test_geometry_extremes();
    test_geometry_restart();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
